>>> sv/c2f_pkg.sv
// Shared constants, types and tables of the Cartesian-to-Frenet converter.
package c2f_pkg;

	localparam int MAX_WAYPOINTS = 256;
	localparam int IDX_W = $clog2(MAX_WAYPOINTS);
	localparam int CNT_W = $clog2(MAX_WAYPOINTS) + 1;
	localparam int COORD_W = 24;
	localparam int HEAD_W = 16;

	localparam int CENTER_X_Q8 = 1000 * 256;
	localparam int CENTER_Y_Q8 = 2000 * 256;
	localparam logic [63:0] FAR_SQ = 64'd655360000000000;
	localparam int PI_Q16 = 205887;
	localparam int QUARTER_PI_Q12 = 3217;
	localparam int D_MAX = 8388607;
	localparam int S_MAX = 16777215;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic issue;
		logic sh32;
		logic clr;
	} mac_ctl_t;

	typedef struct packed {
		logic op;
		logic [7:0] idx;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [HEAD_W-1:0] head;
	} c2f_req_t;

	typedef struct packed {
		logic [7:0] nxt;
		logic [23:0] d;
		logic [23:0] s;
	} c2f_res_t;

	// Arctangent of 2^-k in Q.16 radians for the CORDIC steps.
	function automatic logic signed [19:0] atan_q16(input logic [3:0] k);
		logic signed [19:0] v;
		case (k)
			4'd0: v = 20'sd51472;
			4'd1: v = 20'sd30386;
			4'd2: v = 20'sd16055;
			4'd3: v = 20'sd8150;
			4'd4: v = 20'sd4091;
			4'd5: v = 20'sd2047;
			4'd6: v = 20'sd1024;
			4'd7: v = 20'sd512;
			4'd8: v = 20'sd256;
			4'd9: v = 20'sd128;
			4'd10: v = 20'sd64;
			4'd11: v = 20'sd32;
			4'd12: v = 20'sd16;
			4'd13: v = 20'sd8;
			4'd14: v = 20'sd4;
			4'd15: v = 20'sd2;
			default: v = 20'sd0;
		endcase
		return v;
	endfunction

endpackage

>>> sv/cartesian_to_frenet.sv
// Cartesian-to-Frenet converter: a waypoint map, a sequencer and a shared multiply unit.
// A load transaction (tuser 0) writes one waypoint. A query transaction (tuser 1) returns
// one result: the scan of all N effective waypoints runs through the single multiplier,
// and every segment length summed into s costs a two-product job plus a 32-step square
// root on the shared compare-subtract unit. The input is not ready while a query is in
// progress; a finished result waits in the output register while the next transaction
// is accepted.
module cartesian_to_frenet import c2f_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [71:0]      s_tdata,  // waypoint_index, pos_x, pos_y, heading
	input  logic [0:0]       s_tuser,  // operation
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [55:0]      m_tdata,  // s distance, d offset, next_waypoint
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	logic [CNT_W-1:0] count_q;
	logic m_tvalid_q;
	logic [55:0] m_tdata_q;
	c2f_req_t req;
	c2f_res_t res;
	logic req_ready, res_valid, res_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(2);
		end else if (cfg_valid) begin
			count_q <= cfg_data;
		end
	end

	assign req.op = s_tuser[0];
	assign req.idx = s_tdata[7:0];
	assign req.x = s_tdata[31:8];
	assign req.y = s_tdata[55:32];
	assign req.head = s_tdata[71:56];
	assign s_tready = req_ready;
	assign res_ready = !m_tvalid_q || m_tready;

	c2f_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid && req_ready),
		.req      (req),
		.req_ready(req_ready),
		.count    (count_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == OP_QUERY) |=> !s_tready)
		else $error("input still ready after a query transaction");
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == OP_LOAD) |=> s_tready)
		else $error("input not ready after a waypoint load");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output transaction changed while it was waiting");
`endif

endmodule

>>> sv/c2f_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c2f_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/c2f_mac.sv
// Shared multiply-accumulate unit: 33x33 signed product, registered, summed modulo 2^64.
module c2f_mac import c2f_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  mac_ctl_t           ctl,
	input  logic signed [32:0] opa,
	input  logic signed [32:0] opb,
	output logic [63:0]        acc
);

	logic signed [65:0] prod;
	logic [63:0] prod_s1;
	logic valid_s1;
	logic [63:0] acc_q;

	assign prod = opa * opb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
		end
	end

	// A partial product of high and low halves only contributes its low word, moved up.
	always_ff @(posedge clk) begin
		prod_s1 <= ctl.sh32 ? {prod[31:0], 32'd0} : prod[63:0];
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (valid_s1) begin
			acc_q <= acc_q + prod_s1;
		end
	end

	assign acc = acc_q;

endmodule

>>> sv/c2f_core.sv
// Sequencer and datapath: closest-waypoint scan, CORDIC bearing, projection, roots and sums.
module c2f_core import c2f_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  c2f_req_t         req,
	output logic             req_ready,
	input  logic [CNT_W-1:0] count,
	output logic             res_valid,
	input  logic             res_ready,
	output c2f_res_t         res
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_SC_RD  = 5'd1;
	localparam logic [4:0] ST_SC_LD  = 5'd2;
	localparam logic [4:0] ST_SC_CMP = 5'd3;
	localparam logic [4:0] ST_BR_RD  = 5'd4;
	localparam logic [4:0] ST_BR_LD  = 5'd5;
	localparam logic [4:0] ST_BR_IT  = 5'd6;
	localparam logic [4:0] ST_HEAD   = 5'd7;
	localparam logic [4:0] ST_NX_RD  = 5'd8;
	localparam logic [4:0] ST_NX_LD  = 5'd9;
	localparam logic [4:0] ST_PV_LD  = 5'd10;
	localparam logic [4:0] ST_J_NN   = 5'd11;
	localparam logic [4:0] ST_J_DOT  = 5'd12;
	localparam logic [4:0] ST_DIV    = 5'd13;
	localparam logic [4:0] ST_T_SET  = 5'd14;
	localparam logic [4:0] ST_T_X    = 5'd15;
	localparam logic [4:0] ST_T_Y    = 5'd16;
	localparam logic [4:0] ST_D_RES  = 5'd17;
	localparam logic [4:0] ST_N1     = 5'd18;
	localparam logic [4:0] ST_N2     = 5'd19;
	localparam logic [4:0] ST_P_RES  = 5'd20;
	localparam logic [4:0] ST_SG_CHK = 5'd21;
	localparam logic [4:0] ST_SG_LD0 = 5'd22;
	localparam logic [4:0] ST_SG_LD1 = 5'd23;
	localparam logic [4:0] ST_SG_ADD = 5'd24;
	localparam logic [4:0] ST_MUL    = 5'd25;
	localparam logic [4:0] ST_MULW   = 5'd26;
	localparam logic [4:0] ST_SQL    = 5'd27;
	localparam logic [4:0] ST_SQ     = 5'd28;
	localparam logic [4:0] ST_DONE   = 5'd29;

	localparam int NUM_W = 53;
	localparam int DIV_STEPS = 69;
	localparam int SQRT_STEPS = 32;
	localparam int CORDIC_STEPS = 16;

	logic [4:0] state_q;
	logic [CNT_W-1:0] n_q, i_q;
	logic [63:0] best_q;
	logic [IDX_W-1:0] closest_q, nxt_q, prv_q;
	logic signed [COORD_W-1:0] px_q, py_q, wnx_q, wny_q;
	logic signed [HEAD_W-1:0] th_q;
	logic signed [27:0] cd_x_q, cd_y_q;
	logic signed [19:0] cd_z_q;
	logic [6:0] cnt_q;
	logic signed [24:0] nx_q, ny_q, xx_q, xy_q;
	logic signed [25:0] cx_q, cy_q;
	logic [63:0] nn_q, q_q, dv_r_q;
	logic [NUM_W-1:0] dv_num_q;
	logic dneg_q, neg_q;
	logic signed [63:0] t_q, prx_q, pry_q;
	logic [63:0] sq_v_q, sq_r_q, sq_b_q, e1_q;
	logic [22:0] dmag_q;
	logic [41:0] s_q;
	logic [63:0] ja1_q, jb1_q, ja2_q, jb2_q;
	logic jlong_q;
	logic [2:0] mstep_q;
	logic [4:0] mret_q, sret_q;

	logic [2*COORD_W-1:0] rd;
	logic [IDX_W-1:0] raddr;
	logic we;
	logic signed [COORD_W-1:0] rx, ry;
	logic signed [24:0] dsx, dsy, nx_c, ny_c, gx_c, gy_c;
	logic signed [27:0] bx, by;
	logic signed [27:0] cdsx, cdsy;
	logic signed [19:0] cz8;
	logic signed [15:0] bear;
	logic signed [16:0] ang, angm;
	logic [CNT_W-1:0] c1;
	logic [IDX_W-1:0] nxt_c, prv_c;
	logic signed [63:0] xx64, xy64, cx64, cy64, nx64, ny64;
	logic signed [63:0] pr_sum, pr_c, tneg;
	logic [63:0] dot_abs, rn, cs_lhs, cs_rhs, cs_diff, rb;
	logic cs_ge;
	logic [63:0] acc;
	mac_ctl_t mctl;
	logic signed [32:0] opa, opb;
	logic [2:0] mlast;
	logic [23:0] d24;

	c2f_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_WAYPOINTS)) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(req.idx[IDX_W-1:0]),
		.wdata({req.y, req.x}),
		.raddr(raddr),
		.rdata(rd)
	);

	c2f_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mctl),
		.opa   (opa),
		.opb   (opb),
		.acc   (acc)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign we = req_valid && req_ready && (req.op == OP_LOAD);

	assign rx = rd[COORD_W-1:0];
	assign ry = rd[2*COORD_W-1:COORD_W];
	assign dsx = 25'(rx) - 25'(px_q);
	assign dsy = 25'(ry) - 25'(py_q);
	assign bx = 28'(rx) - 28'(px_q);
	assign by = 28'(ry) - 28'(py_q);
	assign nx_c = 25'(wnx_q) - 25'(rx);
	assign ny_c = 25'(wny_q) - 25'(ry);
	assign gx_c = 25'(rx) - 25'(wnx_q);
	assign gy_c = 25'(ry) - 25'(wny_q);

	assign cdsx = cd_x_q >>> cnt_q[3:0];
	assign cdsy = cd_y_q >>> cnt_q[3:0];
	assign cz8 = cd_z_q + 20'sd8;
	assign bear = cz8[19:4];
	assign ang = 17'(th_q) - 17'(bear);
	assign angm = ang[16] ? -ang : ang;
	assign c1 = CNT_W'(closest_q) + CNT_W'(1);

	// The heading test picks the waypoint ahead; the one before it closes the segment.
	always_comb begin
		if (angm > 17'(QUARTER_PI_Q12)) begin
			nxt_c = (c1 >= n_q) ? '0 : c1[IDX_W-1:0];
		end else begin
			nxt_c = closest_q;
		end
		prv_c = (nxt_c == '0) ? IDX_W'(n_q - CNT_W'(1)) : nxt_c - IDX_W'(1);
	end

	assign xx64 = 64'(xx_q);
	assign xy64 = 64'(xy_q);
	assign cx64 = 64'(cx_q);
	assign cy64 = 64'(cy_q);
	assign nx64 = 64'(nx_q);
	assign ny64 = 64'(ny_q);
	assign pr_sum = signed'(acc) + 64'sd32768;
	assign pr_c = pr_sum >>> 16;
	assign tneg = dneg_q ? -signed'(q_q) : signed'(q_q);
	assign dot_abs = acc[63] ? -acc : acc;

	// One compare-subtract serves both the long division and the square root.
	assign rn = {dv_r_q[62:0], dv_num_q[NUM_W-1]};
	assign rb = sq_r_q + sq_b_q;
	assign cs_lhs = (state_q == ST_DIV) ? rn : sq_v_q;
	assign cs_rhs = (state_q == ST_DIV) ? nn_q : rb;
	assign cs_ge = cs_lhs >= cs_rhs;
	assign cs_diff = cs_lhs - cs_rhs;

	// Short jobs take one product per pair; long ones build each 64-bit product from halves.
	assign mlast = jlong_q ? 3'd5 : 3'd1;
	always_comb begin
		mctl = '0;
		mctl.clr = (state_q != ST_MUL) && (state_q != ST_MULW);
		mctl.issue = (state_q == ST_MUL);
		opa = '0;
		opb = '0;
		if (!jlong_q) begin
			opa = mstep_q[0] ? ja2_q[32:0] : ja1_q[32:0];
			opb = mstep_q[0] ? jb2_q[32:0] : jb1_q[32:0];
		end else begin
			case (mstep_q)
				3'd0: begin
					opa = {1'b0, ja1_q[31:0]};
					opb = {1'b0, jb1_q[31:0]};
				end
				3'd1: begin
					opa = {1'b0, ja1_q[31:0]};
					opb = {1'b0, jb1_q[63:32]};
					mctl.sh32 = 1'b1;
				end
				3'd2: begin
					opa = {1'b0, ja1_q[63:32]};
					opb = {1'b0, jb1_q[31:0]};
					mctl.sh32 = 1'b1;
				end
				3'd3: begin
					opa = {1'b0, ja2_q[31:0]};
					opb = {1'b0, jb2_q[31:0]};
				end
				3'd4: begin
					opa = {1'b0, ja2_q[31:0]};
					opb = {1'b0, jb2_q[63:32]};
					mctl.sh32 = 1'b1;
				end
				3'd5: begin
					opa = {1'b0, ja2_q[63:32]};
					opb = {1'b0, jb2_q[31:0]};
					mctl.sh32 = 1'b1;
				end
				default: begin
					opa = '0;
					opb = '0;
				end
			endcase
		end
	end

	always_comb begin
		case (state_q)
			ST_SC_RD:  raddr = i_q[IDX_W-1:0];
			ST_BR_RD:  raddr = closest_q;
			ST_NX_RD:  raddr = nxt_q;
			ST_NX_LD:  raddr = prv_q;
			ST_SG_CHK: raddr = i_q[IDX_W-1:0];
			ST_SG_LD0: raddr = i_q[IDX_W-1:0] + IDX_W'(1);
			default:   raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid && req.op == OP_QUERY) begin
						px_q <= req.x;
						py_q <= req.y;
						th_q <= req.head;
						if (count < CNT_W'(2)) n_q <= CNT_W'(2);
						else if (count > CNT_W'(MAX_WAYPOINTS)) n_q <= CNT_W'(MAX_WAYPOINTS);
						else n_q <= count;
						i_q <= '0;
						best_q <= FAR_SQ;
						closest_q <= '0;
						state_q <= ST_SC_RD;
					end
				end
				ST_SC_RD: state_q <= ST_SC_LD;
				ST_SC_LD: begin
					ja1_q <= 64'(dsx);
					jb1_q <= 64'(dsx);
					ja2_q <= 64'(dsy);
					jb2_q <= 64'(dsy);
					jlong_q <= 1'b0;
					mstep_q <= '0;
					mret_q <= ST_SC_CMP;
					state_q <= ST_MUL;
				end
				ST_SC_CMP: begin
					if (acc < best_q) begin
						best_q <= acc;
						closest_q <= i_q[IDX_W-1:0];
					end
					if (i_q == n_q - CNT_W'(1)) begin
						state_q <= ST_BR_RD;
					end else begin
						i_q <= i_q + CNT_W'(1);
						state_q <= ST_SC_RD;
					end
				end
				ST_BR_RD: state_q <= ST_BR_LD;
				ST_BR_LD: begin
					cnt_q <= '0;
					if (bx == '0 && by == '0) begin
						cd_z_q <= '0;
						state_q <= ST_HEAD;
					end else begin
						if (bx < 0) begin
							cd_x_q <= -bx;
							cd_y_q <= -by;
							cd_z_q <= (by >= 0) ? 20'(PI_Q16) : -20'(PI_Q16);
						end else begin
							cd_x_q <= bx;
							cd_y_q <= by;
							cd_z_q <= '0;
						end
						state_q <= ST_BR_IT;
					end
				end
				ST_BR_IT: begin
					if (cd_y_q >= 0) begin
						cd_x_q <= cd_x_q + cdsy;
						cd_y_q <= cd_y_q - cdsx;
						cd_z_q <= cd_z_q + atan_q16(cnt_q[3:0]);
					end else begin
						cd_x_q <= cd_x_q - cdsy;
						cd_y_q <= cd_y_q + cdsx;
						cd_z_q <= cd_z_q - atan_q16(cnt_q[3:0]);
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(CORDIC_STEPS - 1)) state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					nxt_q <= nxt_c;
					prv_q <= prv_c;
					state_q <= ST_NX_RD;
				end
				ST_NX_RD: state_q <= ST_NX_LD;
				ST_NX_LD: begin
					wnx_q <= rx;
					wny_q <= ry;
					state_q <= ST_PV_LD;
				end
				ST_PV_LD: begin
					nx_q <= nx_c;
					ny_q <= ny_c;
					xx_q <= 25'(px_q) - 25'(rx);
					xy_q <= 25'(py_q) - 25'(ry);
					cx_q <= 26'(CENTER_X_Q8) - 26'(rx);
					cy_q <= 26'(CENTER_Y_Q8) - 26'(ry);
					ja1_q <= 64'(nx_c);
					jb1_q <= 64'(nx_c);
					ja2_q <= 64'(ny_c);
					jb2_q <= 64'(ny_c);
					jlong_q <= 1'b0;
					mstep_q <= '0;
					mret_q <= ST_J_NN;
					state_q <= ST_MUL;
				end
				ST_J_NN: begin
					nn_q <= acc;
					ja1_q <= xx64;
					jb1_q <= nx64;
					ja2_q <= xy64;
					jb2_q <= ny64;
					jlong_q <= 1'b0;
					mstep_q <= '0;
					mret_q <= ST_J_DOT;
					state_q <= ST_MUL;
				end
				ST_J_DOT: begin
					dneg_q <= acc[63];
					dv_num_q <= dot_abs[NUM_W-1:0];
					dv_r_q <= '0;
					q_q <= '0;
					cnt_q <= '0;
					state_q <= (nn_q == '0) ? ST_T_SET : ST_DIV;
				end
				ST_DIV: begin
					dv_r_q <= cs_ge ? cs_diff : rn;
					q_q <= {q_q[62:0], cs_ge};
					dv_num_q <= {dv_num_q[NUM_W-2:0], 1'b0};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(DIV_STEPS - 1)) state_q <= ST_T_SET;
				end
				ST_T_SET: begin
					t_q <= tneg;
					ja1_q <= tneg;
					jb1_q <= nx64;
					ja2_q <= '0;
					jb2_q <= '0;
					jlong_q <= 1'b1;
					mstep_q <= '0;
					mret_q <= ST_T_X;
					state_q <= ST_MUL;
				end
				ST_T_X: begin
					prx_q <= pr_c;
					ja1_q <= t_q;
					jb1_q <= ny64;
					ja2_q <= '0;
					jb2_q <= '0;
					mstep_q <= '0;
					mret_q <= ST_T_Y;
					state_q <= ST_MUL;
				end
				ST_T_Y: begin
					pry_q <= pr_c;
					ja1_q <= xx64 - prx_q;
					jb1_q <= xx64 - prx_q;
					ja2_q <= xy64 - pr_c;
					jb2_q <= xy64 - pr_c;
					mstep_q <= '0;
					mret_q <= ST_SQL;
					sret_q <= ST_D_RES;
					state_q <= ST_MUL;
				end
				ST_D_RES: begin
					dmag_q <= (sq_r_q > 64'(D_MAX)) ? 23'(D_MAX) : sq_r_q[22:0];
					ja1_q <= cx64 - xx64;
					jb1_q <= cx64 - xx64;
					ja2_q <= cy64 - xy64;
					jb2_q <= cy64 - xy64;
					jlong_q <= 1'b0;
					mstep_q <= '0;
					mret_q <= ST_N1;
					state_q <= ST_MUL;
				end
				ST_N1: begin
					e1_q <= acc;
					ja1_q <= cx64 - prx_q;
					jb1_q <= cx64 - prx_q;
					ja2_q <= cy64 - pry_q;
					jb2_q <= cy64 - pry_q;
					jlong_q <= 1'b1;
					mstep_q <= '0;
					mret_q <= ST_N2;
					state_q <= ST_MUL;
				end
				ST_N2: begin
					neg_q <= (e1_q <= acc);
					ja1_q <= prx_q;
					jb1_q <= prx_q;
					ja2_q <= pry_q;
					jb2_q <= pry_q;
					mstep_q <= '0;
					mret_q <= ST_SQL;
					sret_q <= ST_P_RES;
					state_q <= ST_MUL;
				end
				ST_P_RES: begin
					s_q <= 42'(sq_r_q[31:0]);
					i_q <= '0;
					state_q <= ST_SG_CHK;
				end
				ST_SG_CHK: begin
					state_q <= (i_q < CNT_W'(prv_q)) ? ST_SG_LD0 : ST_DONE;
				end
				ST_SG_LD0: begin
					wnx_q <= rx;
					wny_q <= ry;
					state_q <= ST_SG_LD1;
				end
				ST_SG_LD1: begin
					ja1_q <= 64'(gx_c);
					jb1_q <= 64'(gx_c);
					ja2_q <= 64'(gy_c);
					jb2_q <= 64'(gy_c);
					jlong_q <= 1'b0;
					mstep_q <= '0;
					mret_q <= ST_SQL;
					sret_q <= ST_SG_ADD;
					state_q <= ST_MUL;
				end
				ST_SG_ADD: begin
					s_q <= s_q + 42'(sq_r_q[31:0]);
					i_q <= i_q + CNT_W'(1);
					state_q <= ST_SG_CHK;
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == mlast) state_q <= ST_MULW;
				end
				ST_MULW: state_q <= mret_q;
				ST_SQL: begin
					sq_v_q <= acc;
					sq_r_q <= '0;
					sq_b_q <= 64'h4000_0000_0000_0000;
					cnt_q <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (cs_ge) begin
						sq_v_q <= cs_diff;
						sq_r_q <= (sq_r_q >> 1) + sq_b_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_b_q <= sq_b_q >> 2;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(SQRT_STEPS - 1)) state_q <= sret_q;
				end
				ST_DONE: begin
					if (res_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign d24 = {1'b0, dmag_q};
	assign res_valid = (state_q == ST_DONE);
	assign res.s = (s_q > 42'(S_MAX)) ? 24'(S_MAX) : s_q[23:0];
	assign res.d = neg_q ? -d24 : d24;
	assign res.nxt = nxt_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (nn_q != '0))
		else $error("division entered with a zero segment length");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SC_CMP) |-> (acc[63:51] == '0))
		else $error("scan distance exceeds its exact range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SG_LD1) |-> (i_q < CNT_W'(prv_q)))
		else $error("segment sum ran past the previous waypoint");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULW) |=> (mctl.clr || state_q == ST_MUL))
		else $error("accumulator not cleared after a job");
`endif

endmodule

>>> sim/c2f_checker.sv
// Checker for the Cartesian-to-Frenet converter: watches all channels, predicts and compares.
module c2f_checker import c2f_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [71:0]      s_tdata,
	input  logic [0:0]       s_tuser,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [55:0]      m_tdata,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending,
	output int               checked
);

	typedef struct packed {
		logic [23:0] s;
		logic [23:0] d;
		logic [7:0]  nxt;
	} frenet_t;

	longint          wp_x [MAX_WAYPOINTS];
	longint          wp_y [MAX_WAYPOINTS];
	logic [CNT_W-1:0] track_len;
	frenet_t         frenet_q[$];
	int              fails;
	int              n_checked;

	assign fail_count = fails;
	assign pending = frenet_q.size();
	assign checked = n_checked;

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] sq_sum(input longint dx, input longint dy);
		return dx * dx + dy * dy;
	endfunction

	// 16-step CORDIC vectoring, angle in Q.16, rounded to Q3.12.
	function automatic longint bearing(input longint dx, input longint dy);
		longint x, y, z, nx, ny;
		longint atan_tab [16];
		atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		x = dx;
		y = dy;
		z = 0;
		if (dx == 0 && dy == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI_Q16 : -PI_Q16;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + atan_tab[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - atan_tab[i];
			end
			x = nx;
			y = ny;
		end
		return (z + 8) >>> 4;
	endfunction

	// Bit-serial floor(num * 2^16 / den); upper quotient bits fall off as in a 64-bit register.
	function automatic logic [63:0] ratio_q16(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q, r, bitv;
		q = 0;
		r = 0;
		for (int pos = 68; pos >= 0; pos--) begin
			bitv = (pos >= 16) ? ((num >> (pos - 16)) & 64'd1) : 64'd0;
			r = (r << 1) | bitv;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic frenet_t convert(input longint px, input longint py, input longint hd);
		frenet_t     res;
		int          n, closest, nxt, prv;
		logic [63:0] best, d2, nn, mag, dmag, s;
		longint      ang, nx, ny, xx, xy, dot, t, prx, pry, cx, cy;
		logic        neg;
		n = track_len;
		if (n < 2) n = 2;
		if (n > MAX_WAYPOINTS) n = MAX_WAYPOINTS;
		best = FAR_SQ;
		closest = 0;
		for (int i = 0; i < n; i++) begin
			d2 = sq_sum(wp_x[i] - px, wp_y[i] - py);
			if (d2 < best) begin
				best = d2;
				closest = i;
			end
		end
		ang = hd - bearing(wp_x[closest] - px, wp_y[closest] - py);
		if (ang < 0) ang = -ang;
		nxt = closest;
		if (ang > QUARTER_PI_Q12) begin
			nxt++;
			if (nxt >= n) nxt = 0;
		end
		prv = (nxt == 0) ? n - 1 : nxt - 1;
		nx = wp_x[nxt] - wp_x[prv];
		ny = wp_y[nxt] - wp_y[prv];
		xx = px - wp_x[prv];
		xy = py - wp_y[prv];
		dot = xx * nx + xy * ny;
		nn = sq_sum(nx, ny);
		t = 0;
		if (nn != 0) begin
			mag = ratio_q16((dot < 0) ? -dot : dot, nn);
			t = (dot < 0) ? -longint'(mag) : longint'(mag);
		end
		prx = (t * nx + 32768) >>> 16;
		pry = (t * ny + 32768) >>> 16;
		dmag = isqrt(sq_sum(xx - prx, xy - pry));
		if (dmag > D_MAX) dmag = D_MAX;
		cx = CENTER_X_Q8 - wp_x[prv];
		cy = CENTER_Y_Q8 - wp_y[prv];
		neg = sq_sum(cx - xx, cy - xy) <= sq_sum(cx - prx, cy - pry);
		s = 0;
		for (int i = 0; i < prv; i++)
			s = s + isqrt(sq_sum(wp_x[i + 1] - wp_x[i], wp_y[i + 1] - wp_y[i]));
		s = s + isqrt(sq_sum(prx, pry));
		if (s > S_MAX) s = S_MAX;
		res.s = s[23:0];
		res.d = neg ? 24'(-dmag) : dmag[23:0];
		res.nxt = nxt[7:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frenet_t got, want;
		if (!arst_n) begin
			track_len <= CNT_W'(2);
			fails = 0;
			n_checked = 0;
			frenet_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				track_len <= cfg_data;
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == OP_LOAD) begin
					wp_x[s_tdata[7:0]] = longint'($signed(s_tdata[31:8]));
					wp_y[s_tdata[7:0]] = longint'($signed(s_tdata[55:32]));
				end else begin
					frenet_q = {frenet_q, convert(longint'($signed(s_tdata[31:8])),
						longint'($signed(s_tdata[55:32])), longint'($signed(s_tdata[71:56])))};
				end
			end
			if (m_tvalid && m_tready) begin
				got.s = m_tdata[23:0];
				got.d = m_tdata[47:24];
				got.nxt = m_tdata[55:48];
				if (frenet_q.size() == 0) begin
					if (fails < 10)
						$display("unexpected result s=%0d d=%0d next=%0d",
							got.s, $signed(got.d), got.nxt);
					fails++;
				end else begin
					want = frenet_q.pop_front();
					n_checked++;
					if (got !== want) begin
						if (fails < 10)
							$display("mismatch: s %0d/%0d d %0d/%0d next %0d/%0d (expected/actual)",
								want.s, got.s, $signed(want.d), $signed(got.d),
								want.nxt, got.nxt);
						fails++;
					end
				end
			end
		end
	end

endmodule

>>> sim/tb_cartesian_to_frenet.sv
// Testbench top for the Cartesian-to-Frenet converter: stimulus, stalls and verdict.
module tb_cartesian_to_frenet;
	import c2f_pkg::*;

	localparam int CYCLE_LIMIT = 5000000;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [71:0]      s_tdata;   // waypoint_index, pos_x, pos_y, heading
	logic [0:0]       s_tuser;   // operation
	logic             m_tvalid;
	logic             m_tready;
	logic [55:0]      m_tdata;   // s distance, d offset, next_waypoint
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;

	int   fail_count, pending, checked;
	int   cycles;
	int   n_loads, n_queries;
	logic hold_off;
	logic press_go;
	int   map_x [MAX_WAYPOINTS];
	int   map_y [MAX_WAYPOINTS];

	cartesian_to_frenet uut (.*);

	c2f_checker chk (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("cartesian_to_frenet verification failed");
			$finish;
		end
	end

	// Output side: random stalls, mostly short, with eager stretches.
	initial begin
		int stall, eager;
		stall = 0;
		eager = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (eager > 0) begin
				eager--;
				m_tready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				case ($urandom_range(0, 99)) inside
					[0:24]: stall = $urandom_range(1, 3);
					[25:28]: stall = $urandom_range(30, 300);
					[29:31]: eager = $urandom_range(200, 2000);
					default: ;
				endcase
			end
		end
	end

	// Long receiver hold-off so that a finished result blocks the next query.
	initial begin
		hold_off = 1'b0;
		@(posedge press_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (4000) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic push_item(input logic op, input int idx, input int x, input int y,
		input int h);
		int gap;
		case ($urandom_range(0, 99)) inside
			[0:59]: gap = 0;
			[60:94]: gap = $urandom_range(1, 3);
			default: gap = $urandom_range(20, 80);
		endcase
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {h[15:0], y[23:0], x[23:0], idx[7:0]};
		do @(posedge clk); while (!s_tready);
		if (op == OP_LOAD) begin
			map_x[idx] = x;
			map_y[idx] = y;
			n_loads++;
		end else begin
			n_queries++;
		end
	endtask

	task automatic load_wp(input int idx, input int x, input int y);
		push_item(OP_LOAD, idx, x, y, $urandom());
	endtask

	task automatic query(input int x, input int y, input int h);
		push_item(OP_QUERY, $urandom(), x, y, h);
	endtask

	// Lets every expected result arrive, then a margin for a trailing load.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_track_len(input int v);
		cfg_valid <= 1'b1;
		cfg_data <= v[CNT_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic int spread(input int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// One random phase: a new track length, fresh leading waypoints, then mostly queries.
	// Entries past the first 32 keep their earlier values, which are always defined.
	task automatic run_phase(input int cfg, input int span, input int items);
		int n, k, r;
		drain();
		set_track_len(cfg);
		n = (cfg < 2) ? 2 : (cfg > MAX_WAYPOINTS) ? MAX_WAYPOINTS : cfg;
		for (int i = 0; i < n && i < 32; i++)
			load_wp(i, spread(span), spread(span));
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, n - 1);
			if (r < 10)
				load_wp($urandom_range(0, 255), spread(span), spread(span));
			else if (r < 16)
				query($signed($urandom() << 8) >>> 8, $signed($urandom() << 8) >>> 8,
					$urandom());
			else if (r < 60)
				query(map_x[k] + spread(span / 8 + 1), map_y[k] + spread(span / 8 + 1),
					$urandom_range(0, 25736) - 12868);
			else
				query(map_x[k] + spread(512), map_y[k] + spread(512), $urandom());
		end
	endtask

	initial begin
		n_loads = 0;
		n_queries = 0;
		press_go = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_LOAD;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry gets a value so no query reads an unwritten waypoint.
		for (int i = 0; i < MAX_WAYPOINTS; i++)
			load_wp(i, spread(4096), spread(4096));

		// Directed: coordinate and heading extremes at the reset track length.
		load_wp(0, -8388608, -8388608);
		load_wp(1, 8388607, 8388607);
		query(-8388608, -8388608, 0);
		query(8388607, -8388608, -32768);
		query(-8388608, 8388607, 32767);
		query(8388607, 8388607, 3217);
		query(256000, 512000, -3217);
		// Duplicate waypoints: tie in distance and a zero-length segment.
		load_wp(0, 25600, 25600);
		load_wp(1, 25600, 25600);
		query(25600, 25600, 0);
		query(30000, 20000, 20000);
		// Three-point track: stepping past the last waypoint wraps to the first.
		drain();
		set_track_len(3);
		load_wp(0, 0, 0);
		load_wp(1, 2560, 0);
		load_wp(2, 2560, 2560);
		query(2560, 2600, 12868);
		query(2600, 2560, -12868);
		query(0, 10, 0);
		query(1280, 300, 0);
		query(1280, -300, 0);
		query(256000, 512000, 6434);

		press_go <= 1'b1;
		run_phase(2, 4096, 70);
		run_phase(5, 16384, 90);
		run_phase(256, 8388607, 8);
		run_phase(0, 8388607, 40);
		run_phase(12, 1024, 90);
		run_phase(300, 65536, 5);
		run_phase(9, 1048576, 90);
		run_phase(511, 1048576, 5);
		run_phase(16, 65536, 80);
		run_phase(3, 8388607, 70);

		drain();
		repeat (200) @(posedge clk);
		$display("Sent %0d waypoint loads and %0d queries; %0d results compared.",
			n_loads, n_queries, checked);
		$display("Track lengths from 2 to 256 were used, including clamped settings 0, 300, 511.");
		if (fail_count == 0)
			$display("cartesian_to_frenet verification clean");
		else
			$display("cartesian_to_frenet verification failed");
		$finish;
	end

endmodule
